[hw/rtl/sss_pkg.sv]
package sss_pkg;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 12;

	localparam logic [CFG_AW-1:0] REG_STEP_DELAY   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_SETTLE_TIME  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_STARTUP_WAIT = 3'd2;
	localparam logic [CFG_AW-1:0] REG_PULSE_LO     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_PULSE_HI     = 3'd4;

	localparam logic [7:0]  RST_STEP_DELAY   = 8'd12;
	localparam logic [9:0]  RST_SETTLE_TIME  = 10'd300;
	localparam logic [11:0] RST_STARTUP_WAIT = 12'd1200;
	localparam logic [11:0] RST_PULSE_LO     = 12'd500;
	localparam logic [11:0] RST_PULSE_HI     = 12'd2500;

	typedef struct packed {
		logic [7:0]  step_delay;
		logic [9:0]  settle_time;
		logic [11:0] startup_wait;
		logic [11:0] pulse_lo;
		logic [11:0] pulse_hi;
	} cfg_t;

	// command characters
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_L_LOWER = 8'h6C;
	localparam logic [7:0] CHAR_L_UPPER = 8'h4C;
	localparam logic [7:0] CHAR_ONE     = 8'h31;
	localparam logic [7:0] CHAR_R_LOWER = 8'h72;
	localparam logic [7:0] CHAR_R_UPPER = 8'h52;
	localparam logic [7:0] CHAR_TWO     = 8'h32;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CMD  = 2'd1,
		OP_NOP  = 2'd2
	} op_kind_t;

	typedef enum logic [1:0] {
		CLS_LEFT  = 2'd0,
		CLS_RIGHT = 2'd1,
		CLS_ALT   = 2'd2
	} cmd_cls_t;

	typedef struct packed {
		op_kind_t kind;
		cmd_cls_t cls;
	} op_t;

	// queue between front and sequencer
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// sweep geometry
	localparam logic [7:0] ANGLE_CENTER = 8'd90;
	localparam logic [7:0] ANGLE_LEFT   = 8'd0;
	localparam logic [7:0] ANGLE_RIGHT  = 8'd180;

	typedef enum logic [4:0] {
		PH_STARTUP = 5'b00001,
		PH_OUT     = 5'b00010,
		PH_SETTLE  = 5'b00100,
		PH_BACK    = 5'b01000,
		PH_IDLE    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] angle;
		logic       busy;
	} seq_res_t;

	// divide by 180 as (p >> 2) / 45, the latter by reciprocal plus one correction
	localparam logic [17:0] DIV_45      = 18'd45;
	localparam logic [18:0] RECIP_45    = 19'd372827;
	localparam int          RECIP_SHIFT = 24;

endpackage

[hw/rtl/sss_item_if.sv]
interface sss_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] cmd_byte;

	modport source(output valid, output action, output cmd_byte, input ready);
	modport sink(input valid, input action, input cmd_byte, output ready);
endinterface

[hw/rtl/sss_result_if.sv]
interface sss_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  angle_deg;
	logic [12:0] compare_ticks;
	logic        busy_res;

	modport source(output valid, output angle_deg, output compare_ticks, output busy_res,
		input ready);
	modport sink(input valid, input angle_deg, input compare_ticks, input busy_res,
		output ready);
endinterface

[hw/rtl/sss_cfg_if.sv]
interface sss_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [sss_pkg::CFG_AW-1:0] addr;
	logic [sss_pkg::CFG_DW-1:0] data;

	modport source(output valid, output addr, output data, input ready);
	modport sink(input valid, input addr, input data, output ready);
endinterface

[hw/rtl/sss_front.sv]
module sss_front (
	sss_item_if.sink      item,
	input  logic          full,
	output logic          push,
	output sss_pkg::op_t  push_op
);

	assign item.ready = !full;
	assign push       = item.valid && !full;

	// classify the beat: tick, ignored line end, or a command with its side
	always_comb begin
		push_op.kind = sss_pkg::OP_TICK;
		push_op.cls  = sss_pkg::CLS_ALT;
		if (item.action) begin
			if (item.cmd_byte == sss_pkg::CHAR_CR || item.cmd_byte == sss_pkg::CHAR_LF) begin
				push_op.kind = sss_pkg::OP_NOP;
			end else begin
				push_op.kind = sss_pkg::OP_CMD;
				if (item.cmd_byte == sss_pkg::CHAR_L_LOWER || item.cmd_byte == sss_pkg::CHAR_L_UPPER
						|| item.cmd_byte == sss_pkg::CHAR_ONE) begin
					push_op.cls = sss_pkg::CLS_LEFT;
				end else if (item.cmd_byte == sss_pkg::CHAR_R_LOWER
						|| item.cmd_byte == sss_pkg::CHAR_R_UPPER
						|| item.cmd_byte == sss_pkg::CHAR_TWO) begin
					push_op.cls = sss_pkg::CLS_RIGHT;
				end
			end
		end
	end

endmodule

[hw/rtl/sss_fifo.sv]
module sss_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sss_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output sss_pkg::op_t  head_op
);

	sss_pkg::op_t                 mem_q [sss_pkg::FIFO_DEPTH];
	logic [sss_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [sss_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [sss_pkg::FIFO_AW:0]    count_q;

	assign full     = count_q == (sss_pkg::FIFO_AW+1)'(sss_pkg::FIFO_DEPTH);
	assign nonempty = count_q != '0;
	assign head_op  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/sss_seq.sv]
module sss_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  sss_pkg::cfg_t     cfg,
	input  logic              op_valid,
	input  sss_pkg::op_t      op,
	input  logic              adv,
	output logic              pop,
	output sss_pkg::seq_res_t res_s1
);

	sss_pkg::phase_t   phase_q, phase_d;
	logic [7:0]        angle_q, angle_d;
	logic [11:0]       tc_q, tc_d, tc_inc;
	logic              right_q, right_d;
	logic              next_right_q, next_right_d;
	logic              pend_q, pend_d;
	sss_pkg::cmd_cls_t pend_cls_q, pend_cls_d;
	logic              start;
	sss_pkg::cmd_cls_t start_cls;
	logic              start_right;
	logic [7:0]        end_angle;
	logic [11:0]       step_ext;
	logic [11:0]       settle_ext;
	logic              valid_s1;
	logic [7:0]        angle_s1;
	logic              busy_s1;

	assign pop        = adv && op_valid;
	assign tc_inc     = tc_q + 12'd1;
	assign step_ext   = {4'b0, cfg.step_delay};
	assign settle_ext = {2'b0, cfg.settle_time};
	assign end_angle  = right_q ? sss_pkg::ANGLE_RIGHT : sss_pkg::ANGLE_LEFT;

	assign res_s1.valid = valid_s1;
	assign res_s1.angle = angle_s1;
	assign res_s1.busy  = busy_s1;

	always_comb begin
		phase_d      = phase_q;
		angle_d      = angle_q;
		tc_d         = tc_q;
		right_d      = right_q;
		next_right_d = next_right_q;
		pend_d       = pend_q;
		pend_cls_d   = pend_cls_q;
		start        = 1'b0;
		start_cls    = op.cls;
		start_right  = 1'b0;
		case (op.kind)
			sss_pkg::OP_TICK: begin
				tc_d = tc_inc;
				case (phase_q)
					sss_pkg::PH_STARTUP: begin
						// startup sweep always goes left and leaves next side alone
						if (tc_inc >= cfg.startup_wait) begin
							phase_d = sss_pkg::PH_OUT;
							angle_d = sss_pkg::ANGLE_CENTER;
							tc_d    = '0;
							right_d = 1'b0;
						end
					end
					sss_pkg::PH_OUT: begin
						if (tc_inc >= step_ext) begin
							tc_d = '0;
							if (angle_q == end_angle) begin
								phase_d = (cfg.settle_time == '0) ? sss_pkg::PH_BACK
									: sss_pkg::PH_SETTLE;
							end else if (right_q) begin
								angle_d = angle_q + 8'd1;
							end else begin
								angle_d = angle_q - 8'd1;
							end
						end
					end
					sss_pkg::PH_SETTLE: begin
						if (tc_inc >= settle_ext) begin
							tc_d    = '0;
							phase_d = sss_pkg::PH_BACK;
						end
					end
					sss_pkg::PH_BACK: begin
						if (tc_inc >= step_ext) begin
							tc_d = '0;
							if (angle_q == sss_pkg::ANGLE_CENTER) begin
								phase_d = sss_pkg::PH_IDLE;
								// launch the held command on this same tick
								if (pend_q) begin
									pend_d    = 1'b0;
									start     = 1'b1;
									start_cls = pend_cls_q;
								end
							end else if (right_q) begin
								angle_d = angle_q - 8'd1;
							end else begin
								angle_d = angle_q + 8'd1;
							end
						end
					end
					default: begin
						tc_d = '0;
					end
				endcase
			end
			sss_pkg::OP_CMD: begin
				if (phase_q == sss_pkg::PH_IDLE) begin
					start     = 1'b1;
					start_cls = op.cls;
				end else if (!pend_q) begin
					pend_d     = 1'b1;
					pend_cls_d = op.cls;
				end
			end
			default: begin
			end
		endcase
		if (start) begin
			case (start_cls)
				sss_pkg::CLS_LEFT:  start_right = 1'b0;
				sss_pkg::CLS_RIGHT: start_right = 1'b1;
				default:            start_right = next_right_q;
			endcase
			next_right_d = !start_right;
			right_d      = start_right;
			angle_d      = sss_pkg::ANGLE_CENTER;
			tc_d         = '0;
			phase_d      = sss_pkg::PH_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sss_pkg::PH_STARTUP;
			angle_q      <= sss_pkg::ANGLE_CENTER;
			tc_q         <= '0;
			right_q      <= 1'b0;
			next_right_q <= 1'b1;
			pend_q       <= 1'b0;
			pend_cls_q   <= sss_pkg::CLS_ALT;
			valid_s1     <= 1'b0;
		end else begin
			if (pop) begin
				phase_q      <= phase_d;
				angle_q      <= angle_d;
				tc_q         <= tc_d;
				right_q      <= right_d;
				next_right_q <= next_right_d;
				pend_q       <= pend_d;
				pend_cls_q   <= pend_cls_d;
			end
			if (adv) begin
				valid_s1 <= op_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s1 <= angle_d;
			busy_s1  <= phase_d == sss_pkg::PH_OUT || phase_d == sss_pkg::PH_SETTLE
				|| phase_d == sss_pkg::PH_BACK;
		end
	end

	a_pend_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> phase_q != sss_pkg::PH_IDLE)
		else $error("held command while idle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q <= sss_pkg::ANGLE_RIGHT)
		else $error("angle out of range");

	a_parked_center: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sss_pkg::PH_IDLE || phase_q == sss_pkg::PH_STARTUP)
			|-> angle_q == sss_pkg::ANGLE_CENTER)
		else $error("parked away from center");

	a_state_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(phase_q) && $stable(angle_q) && $stable(pend_q))
		else $error("sequencer state moved without a beat");

endmodule

[hw/rtl/sss_map.sv]
module sss_map (
	input  logic              clk,
	input  logic              arst_n,
	input  sss_pkg::cfg_t     cfg,
	input  sss_pkg::seq_res_t res_s1,
	output logic              adv,
	sss_result_if.source      result
);

	logic        valid_s2, valid_s3, valid_s4, valid_q;
	logic [7:0]  angle_s2, angle_s3, angle_s4;
	logic        busy_s2, busy_s3, busy_s4;
	logic [19:0] prod_s2;
	logic [17:0] x_s3;
	logic [11:0] q0_s3;
	logic [11:0] q_s4;
	logic [11:0] span;
	logic [17:0] x;
	logic [36:0] recip_prod;
	logic [17:0] rem;
	logic [11:0] pulse;

	// whole back pipeline moves together; stall only when the result is held
	assign adv          = !valid_q || result.ready;
	assign result.valid = valid_q;

	assign span       = cfg.pulse_hi - cfg.pulse_lo;
	assign x          = prod_s2[19:2];
	assign recip_prod = {19'b0, x} * {18'b0, sss_pkg::RECIP_45};
	assign rem        = x_s3 - 18'({6'b0, q0_s3} * sss_pkg::DIV_45);
	assign pulse      = (cfg.pulse_hi < cfg.pulse_lo) ? cfg.pulse_hi
		: cfg.pulse_lo + q_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_s1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_q  <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s2 <= res_s1.angle;
			busy_s2  <= res_s1.busy;
			prod_s2  <= {12'b0, res_s1.angle} * {8'b0, span};

			angle_s3 <= angle_s2;
			busy_s3  <= busy_s2;
			x_s3     <= x;
			q0_s3    <= 12'(recip_prod >> sss_pkg::RECIP_SHIFT);

			// estimate is low by at most one
			angle_s4 <= angle_s3;
			busy_s4  <= busy_s3;
			q_s4     <= (rem >= sss_pkg::DIV_45) ? q0_s3 + 12'd1 : q0_s3;

			result.angle_deg     <= angle_s4;
			result.busy_res      <= busy_s4;
			result.compare_ticks <= {pulse, 1'b0};
		end
	end

endmodule

[hw/rtl/servo_sector_sweep_sequencer_top.sv]
// channel  | role   | beat
// item     | sink   | action, cmd_byte
// result   | source | angle_deg, compare_ticks, busy_res
// cfg      | sink   | addr (register index), data; always ready
//
// One item per cycle sustained while results are taken. The sequencer updates the sweep
// state once per cycle from the head of a four-beat queue when it has an item and adv is
// high; the angle-to-pulse map is a four-stage multiply/reciprocal pipeline.
// Reset puts the sweep in the startup wait at center with registers at their defaults.
// A stalled result freezes the back pipeline; items keep landing until the queue is full.
module servo_sector_sweep_sequencer_top (
	input  logic         clk,
	input  logic         arst_n,
	sss_item_if.sink     item,
	sss_result_if.source result,
	sss_cfg_if.sink      cfg
);

	sss_pkg::cfg_t     cfg_q;
	logic              push;
	sss_pkg::op_t      push_op;
	logic              full;
	logic              pop;
	logic              nonempty;
	sss_pkg::op_t      head_op;
	logic              adv;
	sss_pkg::seq_res_t res_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_delay   <= sss_pkg::RST_STEP_DELAY;
			cfg_q.settle_time  <= sss_pkg::RST_SETTLE_TIME;
			cfg_q.startup_wait <= sss_pkg::RST_STARTUP_WAIT;
			cfg_q.pulse_lo     <= sss_pkg::RST_PULSE_LO;
			cfg_q.pulse_hi     <= sss_pkg::RST_PULSE_HI;
		end else if (cfg.valid) begin
			case (cfg.addr)
				sss_pkg::REG_STEP_DELAY:   cfg_q.step_delay   <= cfg.data[7:0];
				sss_pkg::REG_SETTLE_TIME:  cfg_q.settle_time  <= cfg.data[9:0];
				sss_pkg::REG_STARTUP_WAIT: cfg_q.startup_wait <= cfg.data[11:0];
				sss_pkg::REG_PULSE_LO:     cfg_q.pulse_lo     <= cfg.data[11:0];
				sss_pkg::REG_PULSE_HI:     cfg_q.pulse_hi     <= cfg.data[11:0];
				default: begin
				end
			endcase
		end
	end

	sss_front u_front (
		.item    (item),
		.full    (full),
		.push    (push),
		.push_op (push_op)
	);

	sss_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.head_op  (head_op)
	);

	sss_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op_valid (nonempty),
		.op       (head_op),
		.adv      (adv),
		.pop      (pop),
		.res_s1   (res_s1)
	);

	sss_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.res_s1 (res_s1),
		.adv    (adv),
		.result (result)
	);

endmodule
